### rtl/core/cns_pkg.sv
package cns_pkg;

  // Request action codes.
  typedef enum logic [3:0] {
    ACT_ADVERTISE = 4'd0,
    ACT_HANDLER   = 4'd1,
    ACT_TYPE_CNT  = 4'd2,
    ACT_POOL_TOT  = 4'd3,
    ACT_RESERVE   = 4'd4,
    ACT_IN_USE    = 4'd5,
    ACT_NODE_CNT  = 4'd6,
    ACT_DEMAND    = 4'd7,
    ACT_CHOOSE    = 4'd8
  } action_t;

  localparam logic [15:0] SAT16 = 16'hFFFF;

  // Saturate a 32-bit value to 16 bits.
  function automatic logic [15:0] sat16(input logic [31:0] v);
    sat16 = (v[31:16] != 16'd0) ? SAT16 : v[15:0];
  endfunction

endpackage

### rtl/core/cns_ram.sv
module cns_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/capability_node_selector.sv
// Channel  | Direction | Ports
// -------- | --------- | ----------------------------------------------------------
// request  | in        | in_valid, in_ready, in_action, in_node_index, in_type_index,
//          |           | in_pool_index, in_value, in_flag
// result   | out       | out_valid, out_ready, out_found, out_chosen_node
//
// After reset a clearing pass writes zero to every table entry, one entry of each
// memory per cycle; no request is taken meanwhile. A table write passes through
// ST_WRITE; add reserve first reads the held amount in ST_RSV.
// In a choose one shared compare unit walks each worker's pools and then its
// load compare, one memory read at a time. The result waits in an output register;
// the next request is taken once it leaves.
module capability_node_selector #(
  parameter int NUM_WORKERS = 16,
  parameter int NUM_TYPES   = 8,
  parameter int NUM_POOLS   = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_action,
  input  logic [3:0]  in_node_index,
  input  logic [2:0]  in_type_index,
  input  logic [1:0]  in_pool_index,
  input  logic [31:0] in_value,
  input  logic        in_flag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [3:0]  out_chosen_node
);
  import cns_pkg::*;

  localparam int WB  = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int TB  = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int PB  = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int TD  = NUM_WORKERS * NUM_TYPES;
  localparam int PD  = NUM_WORKERS * NUM_POOLS;
  localparam int TAB = $clog2(TD);
  localparam int PAB = $clog2(PD);
  localparam int CLR = (TD > PD) ? TD : PD;
  localparam int CB  = $clog2(CLR + 1);

  typedef enum logic [9:0] {
    ST_CLEAR = 10'b0000000001,
    ST_IDLE  = 10'b0000000010,
    ST_WRITE = 10'b0000000100,
    ST_RSV   = 10'b0000001000,
    ST_WREAD = 10'b0000010000,
    ST_POOL  = 10'b0000100000,
    ST_LREAD = 10'b0001000000,
    ST_LOAD  = 10'b0010000000,
    ST_NEXT  = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // Request registers.
  logic [3:0]  act_r;
  logic [WB-1:0] node_r;
  logic [TB-1:0] typ_r;
  logic [PB-1:0] pool_r;
  logic [31:0] val_r;
  logic        flag_r, wok_r, tok_r, pok_r;

  // Small per-worker tables, and the per-pool demands, in flops.
  logic [NUM_WORKERS-1:0] adv_r;
  logic [NUM_TYPES-1:0]   hmask_r [NUM_WORKERS];
  logic [15:0]            wbusy_r [NUM_WORKERS];
  logic [31:0]            demand_r [NUM_POOLS];

  // Scan state.
  logic [WB:0]   wi_r;
  logic [PB:0]   pi_r;
  logic          fit_r, found_r;
  logic [WB-1:0] best_r;
  logic [15:0]   bn_r, bd_r, bb_r;
  logic [31:0]   prod_r;
  logic          prod_ph_r;
  logic [CB-1:0] clr_r;

  // Memories.
  logic          lim_we, tbusy_we, cap_we, held_we, used_we;
  logic [TAB-1:0] t_waddr, t_raddr;
  logic [PAB-1:0] p_waddr, p_raddr;
  logic [15:0]   lim_wd, tbusy_wd, lim_rd, tbusy_rd;
  logic [31:0]   cap_wd, held_wd, used_wd, cap_rd, held_rd, used_rd;

  cns_ram #(.WIDTH(16), .DEPTH(TD)) u_lim (.clk(clk), .we(lim_we), .waddr(t_waddr),
    .wdata(lim_wd), .raddr(t_raddr), .rdata(lim_rd));
  cns_ram #(.WIDTH(16), .DEPTH(TD)) u_tbusy (.clk(clk), .we(tbusy_we), .waddr(t_waddr),
    .wdata(tbusy_wd), .raddr(t_raddr), .rdata(tbusy_rd));
  cns_ram #(.WIDTH(32), .DEPTH(PD)) u_cap (.clk(clk), .we(cap_we), .waddr(p_waddr),
    .wdata(cap_wd), .raddr(p_raddr), .rdata(cap_rd));
  cns_ram #(.WIDTH(32), .DEPTH(PD)) u_held (.clk(clk), .we(held_we), .waddr(p_waddr),
    .wdata(held_wd), .raddr(p_raddr), .rdata(held_rd));
  cns_ram #(.WIDTH(32), .DEPTH(PD)) u_used (.clk(clk), .we(used_we), .waddr(p_waddr),
    .wdata(used_wd), .raddr(p_raddr), .rdata(used_rd));

  logic clearing;
  assign clearing = (state_r == ST_CLEAR);

  logic [WB-1:0] wi;
  logic [PB-1:0] pi;
  assign wi = wi_r[WB-1:0];
  assign pi = pi_r[PB-1:0];

  // Read addresses follow the scan in choose, else the request.
  always_comb begin
    if (state_r == ST_IDLE || state_r == ST_WRITE || state_r == ST_RSV) begin
      t_raddr = TAB'(node_r) * TAB'(NUM_TYPES) + TAB'(typ_r);
      p_raddr = PAB'(node_r) * PAB'(NUM_POOLS) + PAB'(pool_r);
    end else begin
      t_raddr = TAB'(wi) * TAB'(NUM_TYPES) + TAB'(typ_r);
      p_raddr = PAB'(wi) * PAB'(NUM_POOLS) + PAB'(pi);
    end
  end

  // Write ports: clearing pass, or the request's table update.
  // Add reserve reads the held amount in ST_RSV and writes the sum in ST_WRITE.
  logic do_w;
  assign do_w = (state_r == ST_WRITE) && wok_r;
  always_comb begin
    t_waddr  = clearing ? TAB'(clr_r) : TAB'(node_r) * TAB'(NUM_TYPES) + TAB'(typ_r);
    p_waddr  = clearing ? PAB'(clr_r) : PAB'(node_r) * PAB'(NUM_POOLS) + PAB'(pool_r);
    lim_we   = (clearing && clr_r < CB'(TD)) ||
               (do_w && tok_r && act_r == ACT_HANDLER);
    tbusy_we = (clearing && clr_r < CB'(TD)) ||
               (do_w && tok_r && act_r == ACT_TYPE_CNT);
    cap_we   = (clearing && clr_r < CB'(PD)) ||
               (do_w && pok_r && act_r == ACT_POOL_TOT);
    held_we  = (clearing && clr_r < CB'(PD)) ||
               (do_w && pok_r && act_r == ACT_RESERVE);
    used_we  = (clearing && clr_r < CB'(PD)) ||
               (do_w && pok_r && act_r == ACT_IN_USE);
    lim_wd   = (clearing || !flag_r) ? 16'd0 : sat16(val_r);
    tbusy_wd = clearing ? 16'd0 : sat16(val_r);
    cap_wd   = clearing ? 32'd0 : val_r;
    used_wd  = clearing ? 32'd0 : val_r;
  end

  // Saturating reserve add.
  logic [32:0] held_sum;
  assign held_sum = {1'b0, held_rd} + {1'b0, val_r};
  assign held_wd  = clearing ? 32'd0 : (held_sum[32] ? 32'hFFFF_FFFF : held_sum[31:0]);

  // Shared pool unit: free amount against demand.
  logic [31:0] shared_amt, avail;
  assign shared_amt = (cap_rd > held_rd) ? cap_rd - held_rd : 32'd0;
  assign avail      = (shared_amt > used_rd) ? shared_amt - used_rd : 32'd0;

  // Load of the scanned worker.
  logic        decl, wfit0;
  logic [15:0] ln, ld;
  assign decl  = hmask_r[wi][typ_r];
  assign wfit0 = adv_r[wi] && (hmask_r[wi] == '0 || decl);
  always_comb begin
    if (decl && lim_rd != 16'd0) begin
      ln = (tbusy_rd < lim_rd) ? tbusy_rd : lim_rd;
      ld = lim_rd;
    end else begin
      ln = 16'd1;
      ld = 16'd1;
    end
  end

  // Shared 16x16 multiplier: n*bd first, then bn*d.
  logic [31:0] mul_out;
  assign mul_out = prod_ph_r ? 32'(bn_r) * 32'(ld) : 32'(ln) * 32'(bd_r);

  logic lim_ok, better;
  assign lim_ok = !(decl && lim_rd != 16'd0 && tbusy_rd >= lim_rd);
  assign better = !found_r || prod_r < mul_out ||
                  (prod_r == mul_out && wbusy_r[wi] < bb_r);

  logic last_w;
  assign last_w = (wi_r == (WB+1)'(NUM_WORKERS - 1));

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == CB'(CLR - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_CHOOSE) begin
            state_nxt = ST_WREAD;
          end else if (in_action == ACT_RESERVE) begin
            state_nxt = ST_RSV;
          end else begin
            state_nxt = ST_WRITE;
          end
        end
      end
      ST_WRITE: state_nxt = ST_IDLE;
      ST_RSV:   state_nxt = ST_WRITE;
      ST_WREAD: state_nxt = !tok_r ? ST_OUT : ST_POOL;
      ST_POOL: begin
        if (pi_r == (PB+1)'(NUM_POOLS)) state_nxt = ST_LREAD;
      end
      ST_LREAD: state_nxt = ST_LOAD;
      ST_LOAD:  if (prod_ph_r) state_nxt = ST_NEXT;
      ST_NEXT:  state_nxt = last_w ? ST_OUT : ST_WREAD;
      ST_OUT:   if (out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = (state_r == ST_OUT);
  assign out_found       = found_r;
  assign out_chosen_node = found_r ? 4'(best_r) : 4'd0;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      adv_r   <= '0;
      found_r <= 1'b0;
      for (int i = 0; i < NUM_WORKERS; i++) begin
        hmask_r[i] <= '0;
        wbusy_r[i] <= '0;
      end
      for (int i = 0; i < NUM_POOLS; i++) begin
        demand_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (clearing) clr_r <= clr_r + CB'(1);
      // Flop table updates.
      if (do_w) begin
        unique case (act_r)
          ACT_ADVERTISE: adv_r[node_r] <= flag_r;
          ACT_HANDLER:   if (tok_r) hmask_r[node_r][typ_r] <= flag_r;
          ACT_NODE_CNT:  wbusy_r[node_r] <= sat16(val_r);
          default: ;
        endcase
      end
      if (state_r == ST_WRITE && act_r == ACT_DEMAND && pok_r) demand_r[pool_r] <= val_r;
      // Scan bookkeeping.
      if (state_r == ST_IDLE && in_valid && in_action == ACT_CHOOSE) found_r <= 1'b0;
      if (state_r == ST_LOAD && prod_ph_r && fit_r && better) found_r <= 1'b1;
      if (state_r == ST_NEXT && last_w) begin
        for (int i = 0; i < NUM_POOLS; i++) demand_r[i] <= '0;
      end
      if (state_r == ST_WREAD && !tok_r) begin
        for (int i = 0; i < NUM_POOLS; i++) demand_r[i] <= '0;
      end
    end
  end

  // Payload and scan datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      act_r  <= in_action;
      node_r <= WB'(in_node_index);
      typ_r  <= TB'(in_type_index);
      pool_r <= PB'(in_pool_index);
      val_r  <= in_value;
      flag_r <= in_flag;
      wok_r  <= 32'(in_node_index) < NUM_WORKERS;
      tok_r  <= 32'(in_type_index) < NUM_TYPES;
      pok_r  <= 32'(in_pool_index) < NUM_POOLS;
      wi_r   <= '0;
      pi_r   <= '0;
      bn_r   <= 16'd0;
      bd_r   <= 16'd1;
      bb_r   <= 16'd0;
      best_r <= '0;
    end
    unique case (state_r)
      ST_WREAD: begin
        fit_r     <= wfit0;
        pi_r      <= (PB+1)'(1);
        prod_ph_r <= 1'b0;
      end
      ST_POOL: begin
        if (pi_r != (PB+1)'(NUM_POOLS)) pi_r <= pi_r + (PB+1)'(1);
        if (avail < demand_r[pi_r == '0 ? PB'(0) : PB'(pi_r - (PB+1)'(1))])
          fit_r <= 1'b0;
      end
      ST_LOAD: begin
        prod_ph_r <= !prod_ph_r;
        if (!prod_ph_r) begin
          prod_r <= mul_out;
          fit_r  <= fit_r && lim_ok;
        end else if (fit_r && better) begin
          best_r <= wi;
          bn_r   <= ln;
          bd_r   <= ld;
          bb_r   <= wbusy_r[wi];
        end
      end
      ST_NEXT: begin
        wi_r <= wi_r + (WB+1)'(1);
        pi_r <= '0;
      end
      default: ;
    endcase
  end

endmodule

### test/capability_node_selector_tb.sv
`timescale 1ns / 100ps

module capability_node_selector_tb;
  import cns_pkg::*;

  localparam int WORKERS = 16;
  localparam int TYPES = 8;
  localparam int POOLS = 4;
  localparam int STALL_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  in_action;
  logic [3:0]  in_node_index;
  logic [2:0]  in_type_index;
  logic [1:0]  in_pool_index;
  logic [31:0] in_value;
  logic        in_flag;
  logic        out_valid;
  logic        out_ready;
  logic        out_found;
  logic [3:0]  out_chosen_node;

  int mismatches = 0;
  int choices_seen = 0;
  int found_seen = 0;
  int requests_sent = 0;
  int send_idle_pct = 19;
  int recv_idle_pct = 70;
  int quiet_cycles = 0;

  // One line per mismatch, counted for the final verdict.
  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  typedef struct packed {
    logic       found;
    logic [3:0] node;
  } choice_t;

  // Scheduler table mirror that predicts each choose outcome.
  class selector_scoreboard;
    logic        adv      [WORKERS];
    logic [7:0]  handlers [WORKERS];
    logic [15:0] limit    [WORKERS][TYPES];
    logic [15:0] type_cnt [WORKERS][TYPES];
    logic [31:0] total    [WORKERS][POOLS];
    logic [31:0] held     [WORKERS][POOLS];
    logic [31:0] in_use   [WORKERS][POOLS];
    logic [15:0] node_cnt [WORKERS];
    logic [31:0] demand   [POOLS];
    choice_t     pending[$];

    function new();
      foreach (adv[w]) begin
        adv[w] = 0;
        handlers[w] = '0;
        node_cnt[w] = '0;
        for (int t = 0; t < TYPES; t++) begin
          limit[w][t] = '0;
          type_cnt[w][t] = '0;
        end
        for (int p = 0; p < POOLS; p++) begin
          total[w][p] = '0;
          held[w][p] = '0;
          in_use[w][p] = '0;
        end
      end
      foreach (demand[p]) demand[p] = '0;
    endfunction

    function logic [15:0] clip16(input logic [31:0] v);
      return (v > 32'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function bit eligible(input int w, input int t);
      logic [31:0] shared, avail;
      bit decl;
      decl = handlers[w][t];
      if (!adv[w]) return 0;
      if (handlers[w] != 0 && !decl) return 0;
      if (decl && limit[w][t] != 0 && type_cnt[w][t] >= limit[w][t]) return 0;
      for (int p = 0; p < POOLS; p++) begin
        shared = (total[w][p] > held[w][p]) ? total[w][p] - held[w][p] : 32'd0;
        avail = (shared > in_use[w][p]) ? shared - in_use[w][p] : 32'd0;
        if (avail < demand[p]) return 0;
      end
      return 1;
    endfunction

    // Note an accepted request; a choose queues its expected outcome.
    function void note_request(input logic [3:0] act, input int w, input int t,
                               input int p, input logic [31:0] v, input logic f);
      logic [32:0] sum;
      logic [31:0] num, den, bn, bd;
      logic [63:0] lhs, rhs;
      logic [15:0] bb;
      choice_t c;
      case (act)
        ACT_ADVERTISE: adv[w] = f;
        ACT_HANDLER: begin
          handlers[w][t] = f;
          limit[w][t] = f ? clip16(v) : 16'd0;
        end
        ACT_TYPE_CNT: type_cnt[w][t] = clip16(v);
        ACT_POOL_TOT: total[w][p] = v;
        ACT_RESERVE: begin
          sum = {1'b0, held[w][p]} + {1'b0, v};
          held[w][p] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
        ACT_IN_USE: in_use[w][p] = v;
        ACT_NODE_CNT: node_cnt[w] = clip16(v);
        ACT_DEMAND: demand[p] = v;
        ACT_CHOOSE: begin
          c = '0;
          bn = 0;
          bd = 1;
          bb = 0;
          for (int i = 0; i < WORKERS; i++) begin
            if (!eligible(i, t)) continue;
            if (handlers[i][t] && limit[i][t] != 0) begin
              den = limit[i][t];
              num = (type_cnt[i][t] < limit[i][t]) ? type_cnt[i][t] : limit[i][t];
            end else begin
              num = 1;
              den = 1;
            end
            lhs = num * 64'(bd);
            rhs = bn * 64'(den);
            if (!c.found || lhs < rhs || (lhs == rhs && node_cnt[i] < bb)) begin
              c.found = 1;
              c.node = i[3:0];
              bn = num;
              bd = den;
              bb = node_cnt[i];
            end
          end
          foreach (demand[q]) demand[q] = '0;
          pending.push_back(c);
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted result against the oldest expectation.
    task check_result(input logic fnd, input logic [3:0] node);
      choice_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result found=%0d node=%0d", fnd, node));
        return;
      end
      e = pending.pop_front();
      if (fnd !== e.found)
        report_mismatch($sformatf("found %0d, expected %0d", fnd, e.found));
      if (node !== e.node)
        report_mismatch($sformatf("chosen_node %0d, expected %0d", node, e.node));
    endtask
  endclass

  selector_scoreboard sb;

  capability_node_selector dut (.*);

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Result side: random back-pressure, checking and the watchdog.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_valid && out_ready) begin
        sb.check_result(out_found, out_chosen_node);
        choices_seen++;
        if (out_found) found_seen++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Present one request and hold it until the block takes it.
  // Valid drops only while the sender idles, so each edge sees one drive.
  task automatic send_request(input logic [3:0] act, input logic [3:0] w,
                              input logic [2:0] t, input logic [1:0] p,
                              input logic [31:0] v, input logic f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_node_index <= w;
    in_type_index <= t;
    in_pool_index <= p;
    in_value <= v;
    in_flag <= f;
    do @(posedge clk); while (!in_ready);
    sb.note_request(act, w, t, p, v, f);
    requests_sent++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(20);
      3: return $urandom_range(70000);
      default: return $urandom;
    endcase
  endfunction

  // Mostly small amounts so that demands often fit; now and then extremes.
  function automatic logic [31:0] pool_amount();
    return ($urandom_range(9) == 0) ? pick_value() : 32'($urandom_range(100));
  endfunction

  // A random setup burst followed by demands and a choose.
  task automatic random_scenario();
    int n;
    logic [3:0] act;
    logic [31:0] v;
    n = $urandom_range(2, 8);
    for (int k = 0; k < n; k++) begin
      act = 4'($urandom_range(ACT_NODE_CNT));
      if ($urandom_range(29) == 0) act = 4'($urandom_range(9, 15));
      case (act)
        ACT_HANDLER, ACT_TYPE_CNT, ACT_NODE_CNT: v = ($urandom_range(1) == 0) ?
            32'($urandom_range(6)) : pick_value();
        ACT_POOL_TOT: v = ($urandom_range(3) == 0) ? pick_value() : 32'($urandom_range(400));
        ACT_RESERVE, ACT_IN_USE: v = pool_amount();
        default: v = $urandom;
      endcase
      send_request(act, 4'($urandom), 3'($urandom), 2'($urandom), v,
                   (act == ACT_ADVERTISE) ? ($urandom_range(3) != 0) :
                                            1'($urandom_range(1)));
    end
    n = $urandom_range(0, 3);
    for (int k = 0; k < n; k++)
      send_request(ACT_DEMAND, 4'($urandom), 3'($urandom), 2'($urandom), pool_amount(),
                   1'($urandom));
    send_request(ACT_CHOOSE, 4'($urandom), 3'($urandom), 2'($urandom), $urandom,
                 1'($urandom));
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = '0;
    in_node_index = '0;
    in_type_index = '0;
    in_pool_index = '0;
    in_value = '0;
    in_flag = 1'b0;
    out_ready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty tables, each action, saturation and ties.
    send_request(ACT_CHOOSE, 4'd0, 3'd0, 2'd0, 32'd0, 1'b0);
    send_request(ACT_ADVERTISE, 4'd0, 3'd0, 2'd0, 32'd0, 1'b1);
    send_request(ACT_ADVERTISE, 4'd15, 3'd0, 2'd0, 32'd0, 1'b1);
    send_request(ACT_CHOOSE, 4'd0, 3'd7, 2'd0, 32'd0, 1'b0);
    send_request(ACT_NODE_CNT, 4'd0, 3'd0, 2'd0, 32'hFFFF_FFFF, 1'b0);
    send_request(ACT_CHOOSE, 4'd0, 3'd3, 2'd0, 32'd0, 1'b0);
    send_request(ACT_HANDLER, 4'd15, 3'd7, 2'd0, 32'hFFFF_FFFF, 1'b1);
    send_request(ACT_TYPE_CNT, 4'd15, 3'd7, 2'd0, 32'd70000, 1'b0);
    send_request(ACT_CHOOSE, 4'd0, 3'd7, 2'd0, 32'd0, 1'b0);
    send_request(ACT_HANDLER, 4'd0, 3'd2, 2'd0, 32'd4, 1'b1);
    send_request(ACT_TYPE_CNT, 4'd0, 3'd2, 2'd0, 32'd1, 1'b0);
    send_request(ACT_CHOOSE, 4'd0, 3'd2, 2'd0, 32'd0, 1'b0);
    send_request(ACT_CHOOSE, 4'd0, 3'd5, 2'd0, 32'd0, 1'b0);
    send_request(ACT_POOL_TOT, 4'd15, 3'd0, 2'd3, 32'd100, 1'b0);
    send_request(ACT_RESERVE, 4'd15, 3'd0, 2'd3, 32'hFFFF_FFF0, 1'b0);
    send_request(ACT_RESERVE, 4'd15, 3'd0, 2'd3, 32'hFFFF_FFFF, 1'b0);
    send_request(ACT_IN_USE, 4'd0, 3'd0, 2'd3, 32'd5, 1'b0);
    send_request(ACT_DEMAND, 4'd0, 3'd0, 2'd3, 32'd1, 1'b0);
    send_request(ACT_CHOOSE, 4'd0, 3'd7, 2'd0, 32'd0, 1'b0);
    send_request(4'd15, 4'd3, 3'd1, 2'd1, 32'd9, 1'b1);
    send_request(ACT_HANDLER, 4'd0, 3'd2, 2'd0, 32'd0, 1'b0);
    send_request(ACT_CHOOSE, 4'd0, 3'd2, 2'd0, 32'd0, 1'b0);

    // Random: three idling phases.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 70 : 0;
      recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 19 : 0;
      for (int s = 0; s < 19; s++) random_scenario();
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d requests; %0d choices checked, %0d of them found a worker.",
             requests_sent, choices_seen, found_seen);
    if (mismatches == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
